// File: design/prf_pkg.sv
// shared types and constants for the primitive root finder
package prf_pkg;

    localparam int          MODULUS_BITS = 31;
    localparam logic [63:0] PRNG_SEED = 64'd88172645463325252;
    localparam logic [15:0] TRIES_RESET = 16'd1024;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_FAC_INIT,
        ST_FAC_SQ,
        ST_FAC_SQ_CHK,
        ST_FAC_DIV,
        ST_FAC_DIV_CHK,
        ST_FAC_LAST,
        ST_TRY,
        ST_RAND_DIV,
        ST_RAND_DONE,
        ST_Q_LOAD,
        ST_EXP_DIV,
        ST_EXP_DONE,
        ST_POW_STEP,
        ST_POW_MUL,
        ST_POW_SQ,
        ST_POW_CHK,
        ST_DONE
    } state_t;

endpackage

// File: design/primitive_root_finder.sv
// primitive root modulo a prime: top level and sequencer
//
// input channel: s_valid/s_ready with s_prime_modulus, the prime p.
// output channel: m_valid/m_ready with m_root and m_found.
// config: cfg_we/cfg_wdata writes max_tries; write only while idle.
// one word in, one word out. the block takes a word only when idle and
// holds the result in an output register until it is taken; a stalled
// receiver simply holds the block in its done state.
// all divisions and modular reductions run through one shared restoring
// divider. factoring p-1 costs one division per trial divisor up to sqrt(p-1)
// (up to ~46000 divisors), plus one more after each hit; each candidate
// costs one division for the draw plus, per prime factor, one for the
// exponent and one per exponent bit for square-and-multiply, two for a
// set bit.
// reset restores the generator seed and max_tries = 1024; no clearing pass.
module primitive_root_finder
    import prf_pkg::*;
#(
    parameter int MAX_FACTORS  = 9
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [30:0] s_prime_modulus,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [30:0] m_root,
    output logic        m_found,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);
    localparam int FW = $clog2(MAX_FACTORS + 1);
    localparam int IW = (MAX_FACTORS > 1) ? $clog2(MAX_FACTORS) : 1;

    state_t state_reg, state_next;

    logic [63:0] prng_reg, prng_next;
    logic [15:0] tries_max_reg;
    logic [15:0] tries_reg, tries_next;
    logic [31:0] p_reg, p_next;
    logic [31:0] n_reg, n_next;       // remaining cofactor
    logic [31:0] q_reg, q_next;       // trial divisor / current factor
    logic [31:0] g_reg, g_next;
    logic [31:0] e_reg, e_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] b_reg, b_next;
    logic [FW-1:0] cnt_reg, cnt_next;
    logic [FW-1:0] idx_reg, idx_next;
    logic        store_q_reg, store_q_next;  // current q was already stored
    logic [31:0] fac_mem [MAX_FACTORS];
    logic        fac_we;
    logic [31:0] fac_wdata;
    logic [30:0] root_reg, root_next;
    logic        found_reg, found_next;

    logic        div_start;
    logic [63:0] div_a;
    logic [31:0] div_b;
    logic        div_busy;
    logic [63:0] div_q;
    logic [31:0] div_r;

    logic [31:0] order;
    logic [63:0] xs1, xs2, xs3;
    logic [63:0] q_sq;

    prf_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .busy      (div_busy),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign order = p_reg - 32'd1;
    assign xs1   = prng_reg ^ (prng_reg << 13);
    assign xs2   = xs1 ^ (xs1 >> 7);
    assign xs3   = xs2 ^ (xs2 << 17);
    assign q_sq  = q_reg * q_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:        if (s_valid) state_next = ST_FAC_INIT;
            ST_FAC_INIT:    state_next = (p_reg < 32'd2) ? ST_DONE : ST_FAC_SQ;
            ST_FAC_SQ:      state_next = (q_sq > {32'd0, n_reg}) ? ST_FAC_LAST : ST_FAC_DIV;
            ST_FAC_DIV:     state_next = ST_FAC_DIV_CHK;
            ST_FAC_DIV_CHK: if (!div_busy) state_next = ST_FAC_SQ_CHK;
            ST_FAC_SQ_CHK:  state_next = (div_r == 32'd0) ? ST_FAC_DIV : ST_FAC_SQ;
            ST_FAC_LAST:    state_next = ST_TRY;
            ST_TRY:         state_next = (tries_reg >= tries_max_reg) ? ST_DONE : ST_RAND_DIV;
            ST_RAND_DIV:    state_next = ST_RAND_DONE;
            ST_RAND_DONE:   if (!div_busy) state_next = ST_Q_LOAD;
            ST_Q_LOAD:      state_next = (idx_reg >= cnt_reg) ? ST_DONE : ST_EXP_DIV;
            ST_EXP_DIV:     state_next = ST_EXP_DONE;
            ST_EXP_DONE:    if (!div_busy) state_next = ST_POW_STEP;
            ST_POW_STEP:    state_next = (e_reg == 32'd0) ? ST_POW_CHK :
                                         (e_reg[0] ? ST_POW_MUL : ST_POW_SQ);
            ST_POW_MUL:     if (!div_busy) state_next = ST_POW_SQ;
            ST_POW_SQ:      if (!div_busy) state_next = ST_POW_STEP;
            ST_POW_CHK:     state_next = (acc_reg == 32'd1) ? ST_TRY : ST_Q_LOAD;
            ST_DONE:        if (m_ready) state_next = ST_IDLE;
            default:        state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        prng_next    = prng_reg;
        tries_next   = tries_reg;
        p_next       = p_reg;
        n_next       = n_reg;
        q_next       = q_reg;
        g_next       = g_reg;
        e_next       = e_reg;
        acc_next     = acc_reg;
        b_next       = b_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        store_q_next = store_q_reg;
        root_next    = root_reg;
        found_next   = found_reg;
        fac_we       = 1'b0;
        fac_wdata    = q_reg;
        div_start    = 1'b0;
        div_a        = {32'd0, n_reg};
        div_b        = q_reg;
        s_ready      = (state_reg == ST_IDLE);
        m_valid      = (state_reg == ST_DONE);
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    p_next     = 32'(s_prime_modulus) & 32'((64'd1 << MODULUS_BITS) - 64'd1);
                    root_next  = '0;
                    found_next = 1'b0;
                end
            end
            ST_FAC_INIT: begin
                n_next       = order;
                q_next       = 32'd2;
                cnt_next     = '0;
                tries_next   = '0;
                store_q_next = 1'b0;
            end
            ST_FAC_SQ: begin
                if (q_sq <= {32'd0, n_reg}) begin
                    div_start = 1'b1;
                end
            end
            ST_FAC_DIV: begin
                div_start = 1'b1;
            end
            ST_FAC_DIV_CHK: begin
                if (!div_busy && div_r == 32'd0) begin
                    n_next = div_q[31:0];
                    if (!store_q_reg && cnt_reg < FW'(MAX_FACTORS)) begin
                        fac_we   = 1'b1;
                        cnt_next = cnt_reg + FW'(1);
                    end
                    store_q_next = 1'b1;
                end
            end
            ST_FAC_SQ_CHK: begin
                // divide again by the same q after a hit; else move on
                if (div_r != 32'd0) begin
                    q_next       = q_reg + 32'd1;
                    store_q_next = 1'b0;
                end
            end
            ST_FAC_LAST: begin
                fac_wdata = n_reg;
                if (n_reg > 32'd1 && cnt_reg < FW'(MAX_FACTORS)) begin
                    fac_we   = 1'b1;
                    cnt_next = cnt_reg + FW'(1);
                end
            end
            ST_TRY: begin
                if (tries_reg < tries_max_reg) begin
                    prng_next  = xs3;
                    tries_next = tries_reg + 16'd1;
                end
            end
            ST_RAND_DIV: begin
                div_start = 1'b1;
                div_a     = prng_reg;
                div_b     = order;
            end
            ST_RAND_DONE: begin
                if (!div_busy) begin
                    g_next   = div_r + 32'd1;
                    idx_next = '0;
                end
            end
            ST_Q_LOAD: begin
                if (idx_reg >= cnt_reg) begin
                    root_next  = g_reg[30:0];
                    found_next = 1'b1;
                end else begin
                    q_next = fac_mem[idx_reg[IW-1:0]];
                end
            end
            ST_EXP_DIV: begin
                div_start = 1'b1;
                div_a     = {32'd0, order};
                div_b     = q_reg;
            end
            ST_EXP_DONE: begin
                if (!div_busy) begin
                    e_next   = div_q[31:0];
                    acc_next = 32'd1;
                    b_next   = g_reg;   // g < p already
                    idx_next = idx_reg + FW'(1);
                end
            end
            ST_POW_STEP: begin
                if (e_reg != 32'd0) begin
                    div_start = 1'b1;
                    div_b     = p_reg;
                    div_a     = e_reg[0] ? (acc_reg * b_reg) : (b_reg * b_reg);
                end
            end
            ST_POW_MUL: begin
                if (!div_busy) begin
                    acc_next  = div_r;
                    div_start = 1'b1;
                    div_b     = p_reg;
                    div_a     = b_reg * b_reg;
                end
            end
            ST_POW_SQ: begin
                if (!div_busy) begin
                    b_next = div_r;
                    e_next = e_reg >> 1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            prng_reg      <= PRNG_SEED;
            tries_max_reg <= TRIES_RESET;
        end else begin
            state_reg <= state_next;
            prng_reg  <= prng_next;
            if (cfg_we) begin
                tries_max_reg <= cfg_wdata;
            end
        end
        tries_reg   <= tries_next;
        p_reg       <= p_next;
        n_reg       <= n_next;
        q_reg       <= q_next;
        g_reg       <= g_next;
        e_reg       <= e_next;
        acc_reg     <= acc_next;
        b_reg       <= b_next;
        cnt_reg     <= cnt_next;
        idx_reg     <= idx_next;
        store_q_reg <= store_q_next;
        root_reg    <= root_next;
        found_reg   <= found_next;
        if (fac_we) begin
            fac_mem[cnt_reg[IW-1:0]] <= fac_wdata;
        end
    end

    assign m_root  = root_reg;
    assign m_found = found_reg;
endmodule

// File: design/prf_divider.sv
// restoring divider, one quotient bit per cycle, 64-bit dividend
module prf_divider
    import prf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic [63:0] quotient,
    output logic [31:0] remainder
);
    logic [63:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [32:0] trial;
    logic [32:0] shifted;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        shifted   = {rem_reg[31:0], quo_reg[63]};
        trial     = shifted - {1'b0, dvs_reg};
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[32]) begin
                rem_next = trial;
                quo_next = {quo_reg[62:0], 1'b1};
            end else begin
                rem_next = shifted;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[31:0];
endmodule
